// ----- design/rudp_rr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rudp_rr_pkg
// shared constants, event codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package rudp_rr_pkg;

  localparam int DEFAULT_WINDOW_SLOTS     = 16;
  localparam int DEFAULT_MAX_PACKET_BYTES = 65535;
  localparam int RELEASE_CAP              = 16;
  localparam int HEADER_BYTES             = 8;
  localparam int CHECKSUM_LO_BYTE         = 6;
  localparam int CHECKSUM_HI_BYTE         = 7;

  localparam logic [15:0] TYPE_DATA     = 16'd1;
  localparam logic [15:0] TYPE_FILE_END = 16'd3;

  localparam logic [2:0] EV_ACK      = 3'd0;
  localparam logic [2:0] EV_DATA     = 3'd1;
  localparam logic [2:0] EV_FILE_END = 3'd2;
  localparam logic [2:0] EV_CORRUPT  = 3'd3;
  localparam logic [2:0] EV_OOW      = 3'd4;

  typedef struct packed {
    logic take;
    logic eval;
    logic store;
    logic rd;
    logic rel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic done;
    logic verdict_final;
    logic rel_final;
  } status_t;

endpackage

// ----- design/rudp_rr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rudp_rr_ctrl
// sequencer: byte intake, packet verdict and release walk
// ----------------------------------------------------------------------------
module rudp_rr_ctrl
  import rudp_rr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    end_of_packet,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_STORE,
    S_WREAD,
    S_WEMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   walking;

  assign walking  = (state == S_WREAD) || (state == S_WEMIT);
  assign in_stall = !((state == S_IDLE) || (walking && !end_of_packet));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.take   = accept && !sts.done;
    unique case (state)
      S_IDLE: begin
        if (accept && !sts.done && end_of_packet) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        if (sts.out_free) begin
          cmd.store  = 1'b1;
          state_next = sts.verdict_final ? S_IDLE : S_WREAD;
        end
      end
      S_WREAD: begin
        cmd.rd     = 1'b1;
        state_next = S_WEMIT;
      end
      S_WEMIT: begin
        if (sts.out_free) begin
          cmd.rel    = 1'b1;
          state_next = sts.rel_final ? S_IDLE : S_WREAD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/rudp_rr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rudp_rr_dp
// datapath: header capture, checksum, reorder window and result register
// ----------------------------------------------------------------------------
module rudp_rr_dp
  import rudp_rr_pkg::*;
#(
  parameter int WINDOW_SLOTS     = DEFAULT_WINDOW_SLOTS,
  parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  packet_byte,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  event_kind,
  output logic [31:0] sequence_number,
  output logic [15:0] payload_length,
  output logic        final_event
);

  localparam int SW  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SW1 = SW + 1;
  localparam int CW  = $clog2(RELEASE_CAP + 1);

  // packet accumulators
  logic [15:0] run_sum;
  logic [7:0]  low_hold;
  logic [15:0] byte_count;
  logic [15:0] hdr_type;
  logic [31:0] hdr_seq;
  logic [15:0] rx_chk;

  // window state
  logic [31:0]             next_exp;
  logic [SW-1:0]           ne_slot;
  logic                    done;
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [16:0]             slot_mem [WINDOW_SLOTS];
  logic                    rd_end;
  logic [15:0]             rd_len;
  logic [CW-1:0]           rel_cnt;

  // verdict
  logic        v_bad;
  logic        v_below;
  logic [31:0] v_diff;

  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic        byte_live;
  logic        oow;
  logic        do_store;
  logic [SW:0] slot_sum;
  logic [SW-1:0] slot_wr;
  logic [15:0] pkt_len;
  logic [SW-1:0] ne_slot_inc;
  logic [CW-1:0] rel_cnt_inc;
  logic        out_free;

  assign byte_live = cmd.take && (byte_count < 16'(MAX_PACKET_BYTES));
  assign word      = (byte_count == 16'(CHECKSUM_HI_BYTE)) ? 16'h0000
                                                          : {packet_byte, low_hold};
  assign sum_wide  = {1'b0, run_sum} + {1'b0, word};
  assign sum_fold  = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

  assign oow      = !v_below && (v_diff >= 32'(WINDOW_SLOTS));
  assign do_store = !v_bad && !v_below && !oow &&
                    ((hdr_type == TYPE_DATA) || (hdr_type == TYPE_FILE_END));
  assign slot_sum = {1'b0, ne_slot} + {1'b0, v_diff[SW-1:0]};
  assign slot_wr  = (slot_sum >= SW1'(WINDOW_SLOTS)) ? SW'(slot_sum - SW1'(WINDOW_SLOTS))
                                                    : slot_sum[SW-1:0];
  assign pkt_len  = byte_count - 16'(HEADER_BYTES);

  assign ne_slot_inc = (ne_slot == SW'(WINDOW_SLOTS - 1)) ? '0 : (ne_slot + SW'(1));
  assign rel_cnt_inc = rel_cnt + CW'(1);

  assign out_free          = !out_valid || !out_stall;
  assign sts.out_free      = out_free;
  assign sts.done          = done;
  assign sts.verdict_final = !(slot_valid[ne_slot] || (do_store && (v_diff == 32'd0)));
  assign sts.rel_final     = rd_end || (rel_cnt_inc == CW'(RELEASE_CAP)) ||
                             !slot_valid[ne_slot_inc];

  // packet accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.store) begin
      run_sum    <= '0;
      low_hold   <= '0;
      byte_count <= '0;
      hdr_type   <= '0;
      hdr_seq    <= '0;
      rx_chk     <= '0;
    end else if (byte_live) begin
      byte_count <= byte_count + 16'd1;
      if (byte_count < 16'd2) begin
        hdr_type <= {hdr_type[7:0], packet_byte};
      end else if (byte_count < 16'(CHECKSUM_LO_BYTE)) begin
        hdr_seq <= {hdr_seq[23:0], packet_byte};
      end else if (byte_count == 16'(CHECKSUM_LO_BYTE)) begin
        rx_chk <= {8'h00, packet_byte};
      end else if (byte_count == 16'(CHECKSUM_HI_BYTE)) begin
        rx_chk <= {packet_byte, rx_chk[7:0]};
      end
      if (!byte_count[0]) begin
        low_hold <= packet_byte;
      end else begin
        run_sum <= sum_fold;
      end
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      v_bad   <= (byte_count < 16'(HEADER_BYTES)) || (rx_chk != ~run_sum);
      v_below <= hdr_seq < next_exp;
      v_diff  <= hdr_seq - next_exp;
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_exp   <= 32'd1;
      ne_slot    <= SW'(1 % WINDOW_SLOTS);
      done       <= 1'b0;
      slot_valid <= '0;
      rel_cnt    <= '0;
    end else if (cmd.store) begin
      rel_cnt <= '0;
      if (do_store) begin
        slot_valid[slot_wr] <= 1'b1;
      end
    end else if (cmd.rel) begin
      slot_valid[ne_slot] <= 1'b0;
      next_exp            <= next_exp + 32'd1;
      ne_slot             <= ne_slot_inc;
      rel_cnt             <= rel_cnt_inc;
      done                <= rd_end;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.store && do_store) begin
      slot_mem[slot_wr] <= {(hdr_type == TYPE_FILE_END), pkt_len};
    end
    if (cmd.rd) begin
      {rd_end, rd_len} <= slot_mem[ne_slot];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store || cmd.rel) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      payload_length  <= '0;
      final_event     <= sts.verdict_final;
      sequence_number <= v_bad ? 32'd0 : hdr_seq;
      if (v_bad) begin
        event_kind <= EV_CORRUPT;
      end else if (!v_below && oow) begin
        event_kind <= EV_OOW;
      end else begin
        event_kind <= EV_ACK;
      end
    end else if (cmd.rel) begin
      event_kind      <= rd_end ? EV_FILE_END : EV_DATA;
      sequence_number <= next_exp;
      payload_length  <= rd_len;
      final_event     <= sts.rel_final;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.store || cmd.rel) |-> out_free)
    else $error("result emitted while result register busy");

  a_rel_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.rel |-> slot_valid[ne_slot])
    else $error("release from empty slot");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> (done && !cmd.store && !cmd.eval))
    else $error("activity after transfer end");

endmodule

// ----- design/reliable_udp_receive_reorder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_udp_receive_reorder_top
// packet check, ack and in-order release for a selective repeat receiver
// ----------------------------------------------------------------------------
// A byte that does not end a packet is taken while the controller is idle.
// The final byte of a packet is followed by checksum and window evaluation
// (S_EVAL), then the post of the ack, drop or out-of-window result (S_STORE);
// each in-order release then reads slot memory (S_WREAD) and posts the result
// (S_WEMIT), up to sixteen per packet end; a post waits while the output
// is stalled. During the release walk the non-final bytes of the next packet
// are taken; its final byte waits until the walk ends. After the file end
// is released every byte is taken and ignored until reset.
module reliable_udp_receive_reorder_top
  import rudp_rr_pkg::*;
#(
  parameter int WINDOW_SLOTS     = DEFAULT_WINDOW_SLOTS,
  parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [31:0] sequence_number,
  output logic [15:0] payload_length,
  output logic        final_event
);

  cmd_t    cmd;
  status_t sts;

  rudp_rr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_packet (end_of_packet),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  rudp_rr_dp #(
    .WINDOW_SLOTS     (WINDOW_SLOTS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .packet_byte     (packet_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .event_kind      (event_kind),
    .sequence_number (sequence_number),
    .payload_length  (payload_length),
    .final_event     (final_event)
  );

endmodule
